// ===== rtl/tfsd_pkg.sv =====
// Shared types and constants for the three-finger swipe detector.
// No dependencies; imported by the top level and the checker.
package tfsd_pkg;

    localparam int SUM_W      = 17;
    localparam int EL_W       = 16;
    localparam int THR_W      = 16;
    localparam int VEL_W      = 24;
    localparam int COUNT_W    = 4;
    localparam int VNUM_W     = 23;
    localparam int DIV3_W     = 2;
    localparam int IN_TDATA_W = 96;
    localparam int IN_TUSER_W = 3;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [2:0] {
        FUNC_BEGIN  = 3'd0,
        FUNC_UPDATE = 3'd1,
        FUNC_END    = 3'd2,
        FUNC_RESET  = 3'd3,
        FUNC_OTHER  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        V_IGNORE  = 3'd0,
        V_MAYBE   = 3'd1,
        V_TRIGGER = 3'd2,
        V_FINISH  = 3'd3,
        V_CANCEL  = 3'd4
    } verdict_t;

    // Horizontal: NEG is left, POS is right. Vertical: NEG is up, POS is down.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_NEG  = 2'd1,
        DIR_POS  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_STARTED = 2'd1,
        PH_THREE   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_DIV3 = 3'd1,
        S_DIST = 3'd2,
        S_VDIV = 3'd3,
        S_DONE = 3'd4
    } seq_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_THR = 1'b1;

    localparam logic [THR_W-1:0]   MOVE_THR_RST    = 16'd50;
    localparam logic [THR_W-1:0]   TURN_THR_RST    = 16'd6;
    localparam logic [15:0]        NINE_TENTHS_Q16 = 16'd58982;
    localparam logic [DIV3_W-1:0]  DIV3_DEN        = 2'd3;
    localparam logic [COUNT_W-1:0] THREE_POINTS    = 4'd3;

    localparam logic signed [VEL_W-1:0] VEL_ONE = 24'sd256;
    localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;

endpackage

// ===== rtl/three_finger_swipe_detector_unit.sv =====
// Three-finger swipe detector. A three-point update runs two bit-serial division
// passes: mean movement over three on x and y (17 steps), then distance * 256 over
// elapsed time (23 steps). Every other event goes straight to the result register.
// The next item is taken only after the result is registered.
// Reset (rst_n, asynchronous, active low) clears the gesture state and restores
// the default thresholds.
module three_finger_swipe_detector_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_count, gesture_active, any_pressed, sum_x, sum_y,
    // press_sum_x, press_sum_y, elapsed_ms
    input  logic [tfsd_pkg::IN_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [tfsd_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // verdict, horizontal, vertical, speed
    output logic [tfsd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfsd_pkg::THR_W-1:0]        cfg_data
);

    import tfsd_pkg::*;

    logic [2:0]         in_func;
    logic [COUNT_W-1:0] in_count;
    logic               in_active;
    logic               in_pressed;
    logic [SUM_W-1:0]   in_sum_x;
    logic [SUM_W-1:0]   in_sum_y;
    logic [SUM_W-1:0]   in_press_x;
    logic [SUM_W-1:0]   in_press_y;
    logic [EL_W-1:0]    in_el;

    seq_t                     state_reg;
    seq_t                     state_next;
    phase_t                   phase_reg;
    logic                     have_ref_reg;
    logic [SUM_W-1:0]         ref_x_reg;
    logic [SUM_W-1:0]         ref_y_reg;
    dir_t                     horiz_reg;
    dir_t                     vert_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic [THR_W-1:0]         move_thr_reg;
    logic [THR_W-1:0]         turn_thr_reg;

    phase_t                   phase_next;
    logic                     have_ref_next;
    logic [SUM_W-1:0]         ref_x_next;
    logic [SUM_W-1:0]         ref_y_next;
    dir_t                     horiz_next;
    dir_t                     vert_next;
    logic signed [VEL_W-1:0]  vel_next;
    verdict_t                 verdict_next;

    logic [2:0]         func_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               active_reg;
    logic               pressed_reg;
    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [SUM_W-1:0]   rsel_x_reg;
    logic [SUM_W-1:0]   rsel_y_reg;
    logic [EL_W-1:0]    el_reg;
    logic               dx_neg_reg;
    logic               dy_neg_reg;
    logic               three_reg;
    logic               dist_neg_reg;

    logic               accept;
    logic               serial_in;
    logic               div3_start;
    logic               vdiv_start;
    logic               commit;
    logic [SUM_W-1:0]   rsel_x;
    logic [SUM_W-1:0]   rsel_y;
    logic [SUM_W:0]     dx;
    logic [SUM_W:0]     dy;
    logic [SUM_W-1:0]   dx_mag;
    logic [SUM_W-1:0]   dy_mag;

    logic               divx_done;
    logic               divy_done;
    logic               vdiv_done;
    logic [SUM_W-1:0]   qx;
    logic [SUM_W-1:0]   qy;
    logic [VNUM_W-1:0]  vq;
    logic [VNUM_W-1:0]  vnum;
    logic [EL_W-1:0]    el_den;

    logic signed [SUM_W:0] xd;
    logic signed [SUM_W:0] yd;
    logic signed [SUM_W:0] dist_sel;
    logic [SUM_W:0]        dist_abs;

    logic               mul_run_reg;
    logic [3:0]         mul_idx_reg;
    logic               mul_neg_reg;
    logic [VEL_W-1:0]   mul_mag_reg;
    logic [VEL_W-1:0]   mul_hi_reg;
    logic [15:0]        mul_lo_reg;
    logic [VEL_W:0]     mul_sum;
    logic [VEL_W-1:0]   vel_mag;

    logic [VEL_W:0]           dec_mag;
    logic signed [VEL_W+1:0]  dec_s;
    logic signed [VEL_W+1:0]  term_s;
    logic signed [VEL_W+1:0]  vsum;
    logic signed [VEL_W-1:0]  vel_sat;

    logic               x_big;
    logic               y_big;
    logic               x_turn;
    logic               y_turn;
    dir_t               nh;
    dir_t               nv;

    logic                     m_tvalid_reg;
    verdict_t                 out_verdict_reg;
    dir_t                     out_horiz_reg;
    dir_t                     out_vert_reg;
    logic signed [VEL_W-1:0]  out_speed_reg;

    assign in_func    = s_tuser;
    assign in_count   = s_tdata[3:0];
    assign in_active  = s_tdata[4];
    assign in_pressed = s_tdata[5];
    assign in_sum_x   = s_tdata[22:6];
    assign in_sum_y   = s_tdata[39:23];
    assign in_press_x = s_tdata[56:40];
    assign in_press_y = s_tdata[73:57];
    assign in_el      = s_tdata[89:74];

    assign cfg_ready = 1'b1;

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = serial_in ? S_DIV3 : S_DONE;
                end
            end
            S_DIV3:
            begin
                if (divx_done && divy_done)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                if (vdiv_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_tready   = (state_reg == S_IDLE);
        accept     = s_tvalid && s_tready;
        div3_start = accept && serial_in;
        vdiv_start = (state_reg == S_DIST);
        commit     = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        serial_in = (in_func == FUNC_UPDATE) && (phase_reg != PH_NONE)
                    && (in_count == THREE_POINTS);
        rsel_x = have_ref_reg ? ref_x_reg : in_press_x;
        rsel_y = have_ref_reg ? ref_y_reg : in_press_y;
        dx     = {1'b0, in_sum_x} - {1'b0, rsel_x};
        dy     = {1'b0, in_sum_y} - {1'b0, rsel_y};
        dx_mag = dx[SUM_W] ? SUM_W'(-dx) : dx[SUM_W-1:0];
        dy_mag = dy[SUM_W] ? SUM_W'(-dy) : dy[SUM_W-1:0];
        vel_mag = vel_reg[VEL_W-1] ? VEL_W'(-vel_reg) : VEL_W'(vel_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= in_func;
            count_reg   <= in_count;
            active_reg  <= in_active;
            pressed_reg <= in_pressed;
            sum_x_reg   <= in_sum_x;
            sum_y_reg   <= in_sum_y;
            rsel_x_reg  <= rsel_x;
            rsel_y_reg  <= rsel_y;
            el_reg      <= in_el;
            dx_neg_reg  <= dx[SUM_W];
            dy_neg_reg  <= dy[SUM_W];
            three_reg   <= serial_in;
        end
        if (vdiv_start)
        begin
            dist_neg_reg <= dist_sel[SUM_W];
        end
    end

    tfsd_sdiv #(
        .NUM_W (SUM_W),
        .DEN_W (DIV3_W)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div3_start),
        .num   (dx_mag),
        .den   (DIV3_DEN),
        .done  (divx_done),
        .quo   (qx)
    );

    tfsd_sdiv #(
        .NUM_W (SUM_W),
        .DEN_W (DIV3_W)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div3_start),
        .num   (dy_mag),
        .den   (DIV3_DEN),
        .done  (divy_done),
        .quo   (qy)
    );

    always_comb
    begin
        xd       = dx_neg_reg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        yd       = dy_neg_reg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        dist_sel = (xd >= yd) ? xd : yd;
        dist_abs = dist_sel[SUM_W] ? (SUM_W + 1)'(-dist_sel) : dist_sel;
        vnum     = {dist_abs[VNUM_W-9:0], 8'd0};
        el_den   = (el_reg == '0) ? EL_W'(1) : el_reg;
    end

    tfsd_sdiv #(
        .NUM_W (VNUM_W),
        .DEN_W (EL_W)
    ) u_div_v (
        .clk   (clk),
        .rst_n (rst_n),
        .start (vdiv_start),
        .num   (vnum),
        .den   (el_den),
        .done  (vdiv_done),
        .quo   (vq)
    );

    // decay product |v| * 0.9 in Q16, multiplier bits taken LSB first
    assign mul_sum = {1'b0, mul_hi_reg}
                     + (NINE_TENTHS_Q16[mul_idx_reg] ? {1'b0, mul_mag_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_run_reg <= 1'b0;
            mul_idx_reg <= '0;
        end
        else if (div3_start)
        begin
            mul_run_reg <= 1'b1;
            mul_idx_reg <= '0;
        end
        else if (mul_run_reg)
        begin
            mul_idx_reg <= mul_idx_reg + 1'b1;
            if (mul_idx_reg == 4'hF)
            begin
                mul_run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div3_start)
        begin
            mul_mag_reg <= vel_mag;
            mul_neg_reg <= vel_reg[VEL_W-1];
            mul_hi_reg  <= '0;
            mul_lo_reg  <= '0;
        end
        else if (mul_run_reg)
        begin
            mul_hi_reg <= mul_sum[VEL_W:1];
            mul_lo_reg <= {mul_sum[0], mul_lo_reg[15:1]};
        end
    end

    always_comb
    begin
        dec_mag = {1'b0, mul_hi_reg} + (VEL_W + 1)'(mul_lo_reg[15]);
        dec_s   = mul_neg_reg ? -$signed({1'b0, dec_mag}) : $signed({1'b0, dec_mag});
        term_s  = dist_neg_reg ? -$signed({3'b000, vq}) : $signed({3'b000, vq});
        vsum    = dec_s + term_s;
        if (vsum > $signed((VEL_W + 2)'(VEL_MAX)))
        begin
            vel_sat = VEL_MAX;
        end
        else if (vsum < -$signed((VEL_W + 2)'(26'd8388608)))
        begin
            vel_sat = VEL_MIN;
        end
        else
        begin
            vel_sat = vsum[VEL_W-1:0];
        end
    end

    // resolve the event against the gesture state
    always_comb
    begin
        x_big  = qx > {1'b0, move_thr_reg};
        y_big  = qy > {1'b0, move_thr_reg};
        x_turn = qx > {1'b0, turn_thr_reg};
        y_turn = qy > {1'b0, turn_thr_reg};
        nh     = (!dx_neg_reg && (qx != '0)) ? DIR_POS : DIR_NEG;
        nv     = (!dy_neg_reg && (qy != '0)) ? DIR_POS : DIR_NEG;

        phase_next    = phase_reg;
        have_ref_next = have_ref_reg;
        ref_x_next    = ref_x_reg;
        ref_y_next    = ref_y_reg;
        horiz_next    = horiz_reg;
        vert_next     = vert_reg;
        vel_next      = vel_reg;
        verdict_next  = V_IGNORE;

        case (func_reg)
            FUNC_BEGIN:
            begin
                vel_next     = VEL_ONE;
                phase_next   = PH_STARTED;
                verdict_next = V_MAYBE;
            end
            FUNC_UPDATE:
            begin
                if (phase_reg == PH_NONE)
                begin
                    verdict_next = V_CANCEL;
                end
                else if (three_reg)
                begin
                    phase_next    = PH_THREE;
                    have_ref_next = 1'b1;
                    ref_x_next    = rsel_x_reg;
                    ref_y_next    = rsel_y_reg;
                    vel_next      = vel_sat;
                    if (x_big || y_big)
                    begin
                        ref_x_next   = sum_x_reg;
                        ref_y_next   = sum_y_reg;
                        verdict_next = V_TRIGGER;
                        if ((vert_reg == DIR_NONE) || y_turn)
                        begin
                            if ((vert_reg != DIR_NONE) && (vert_reg != nv))
                            begin
                                verdict_next = V_CANCEL;
                            end
                            vert_next = nv;
                        end
                        if ((horiz_reg == DIR_NONE) || x_turn)
                        begin
                            if ((horiz_reg != DIR_NONE) && (horiz_reg != nh))
                            begin
                                verdict_next = V_CANCEL;
                            end
                            horiz_next = nh;
                        end
                    end
                    else
                    begin
                        verdict_next = active_reg ? V_TRIGGER : V_MAYBE;
                    end
                end
                else if (count_reg > THREE_POINTS)
                begin
                    verdict_next = V_CANCEL;
                end
                else if (phase_reg == PH_THREE)
                begin
                    verdict_next = pressed_reg ? V_CANCEL : V_IGNORE;
                end
                else
                begin
                    verdict_next = V_IGNORE;
                end
            end
            FUNC_END:
            begin
                verdict_next = active_reg ? V_FINISH : V_CANCEL;
            end
            FUNC_RESET:
            begin
                phase_next    = PH_NONE;
                have_ref_next = 1'b0;
                ref_x_next    = '0;
                ref_y_next    = '0;
                horiz_next    = DIR_NONE;
                vert_next     = DIR_NONE;
                vel_next      = '0;
            end
            default:
            begin
                verdict_next = V_IGNORE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NONE;
            have_ref_reg <= 1'b0;
            ref_x_reg    <= '0;
            ref_y_reg    <= '0;
            horiz_reg    <= DIR_NONE;
            vert_reg     <= DIR_NONE;
            vel_reg      <= '0;
        end
        else if (commit)
        begin
            phase_reg    <= phase_next;
            have_ref_reg <= have_ref_next;
            ref_x_reg    <= ref_x_next;
            ref_y_reg    <= ref_y_next;
            horiz_reg    <= horiz_next;
            vert_reg     <= vert_next;
            vel_reg      <= vel_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_thr_reg <= MOVE_THR_RST;
            turn_thr_reg <= TURN_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MOVE_THR: move_thr_reg <= cfg_data;
                CFG_TURN_THR: turn_thr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_verdict_reg <= verdict_next;
            out_horiz_reg   <= horiz_next;
            out_vert_reg    <= vert_next;
            out_speed_reg   <= vel_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_speed_reg, out_vert_reg, out_horiz_reg, out_verdict_reg};

endmodule

// ===== rtl/tfsd_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Stand-alone; instantiated by the swipe detector top level.
module tfsd_sdiv #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             take;
    logic [DEN_W:0]   rem_next;
    logic [NUM_W-1:0] quo_next;

    always_comb
    begin
        rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        take      = (rem_shift >= {1'b0, den_reg});
        rem_next  = take ? rem_diff : rem_shift;
        quo_next  = {quo_reg[NUM_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/tfsd_chk.sv =====
// Port-level checks for the three-finger swipe detector, bound to its top level.
// Depends on tfsd_pkg and three_finger_swipe_detector_unit.
module tfsd_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [tfsd_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic [tfsd_pkg::IN_TUSER_W-1:0]   s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tfsd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [tfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [tfsd_pkg::THR_W-1:0]        cfg_data
);

    import tfsd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed or dropped while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken before the first resolved");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= V_CANCEL))
        else $error("verdict code out of range");

    a_dirs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[4:3] != 2'd3) && (m_tdata[6:5] != 2'd3)))
        else $error("direction latch code out of range");

endmodule

bind three_finger_swipe_detector_unit tfsd_chk u_tfsd_chk (.*);
